// ===== hw/rtl/wav_stream_parse_to_mono_unit_macros.svh =====
// assertion helpers for the wav stream parser
`ifndef WAV_STREAM_PARSE_TO_MONO_UNIT_MACROS_SVH
`define WAV_STREAM_PARSE_TO_MONO_UNIT_MACROS_SVH

// cons must hold in the same cycle as ante
`define WSP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// cons must hold in the cycle after ante
`define WSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/wsp_pkg.sv =====
package wsp_pkg;

  // parse phases
  typedef enum logic [3:0] {
    PH_RIFF, PH_RSIZE, PH_WAVE, PH_CHID, PH_CHSZ,
    PH_FMT, PH_SKIP, PH_PAD, PH_DATA, PH_DONE
  } phase_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_REPORT = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  // error codes
  localparam logic [3:0] ERR_NOT_RIFF   = 4'd0;
  localparam logic [3:0] ERR_NOT_WAVE   = 4'd1;
  localparam logic [3:0] ERR_TRUNCATED  = 4'd2;
  localparam logic [3:0] ERR_FMT_SMALL  = 4'd3;
  localparam logic [3:0] ERR_UNSUPP     = 4'd4;
  localparam logic [3:0] ERR_MISSING    = 4'd5;
  localparam logic [3:0] ERR_LAYOUT     = 4'd6;
  localparam logic [3:0] ERR_EMPTY      = 4'd7;
  localparam logic [3:0] ERR_FLOAT_BITS = 4'd8;

  // tags, little endian words
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] FMT_PCM        = 16'd1;
  localparam logic [15:0] FMT_FLOAT      = 16'd3;
  localparam logic [15:0] FMT_EXTENSIBLE = 16'd65534;

  localparam int SUM_W = 40;

  localparam logic [7:0] GUID_TAIL [15] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h10, 8'h00, 8'h80,
    8'h00, 8'h00, 8'hAA, 8'h00, 8'h38, 8'h9B, 8'h71
  };

  // controller to datapath
  typedef struct packed {
    logic   take;
    logic   restart;
    phase_t phase;
    phase_t next;
    logic   fmt_ok;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic k3;
    logic tag_riff;
    logic tag_wave;
    logic id_fmt;
    logic id_data;
    logic size_lt16;
    logic size_zero;
    logic size_odd;
    logic pad;
    logic count_hit;
    logic fmt_ext;
    logic fmt_plain;
    logic size_lt40;
    logic guid_pcm;
    logic guid_flt;
    logic fmt_found;
    logic bits_zero;
    logic chan_zero;
    logic rate_zero;
    logic is_flt;
    logic bits32;
    logic bits_pcm_ok;
    logic chan_over;
    logic frame_done;
  } status_t;

  // expected guid byte g of the subformat
  function automatic logic [7:0] guid_byte(input logic [3:0] g, input logic flt);
    logic [3:0] idx;
    idx = g - 4'd1;
    if (g == 4'd0) return flt ? 8'h03 : 8'h01;
    return GUID_TAIL[idx];
  endfunction

  // ieee single to q1.31, saturating, nan to zero
  function automatic logic [31:0] float_to_q31(input logic [31:0] w);
    logic [7:0]  e;
    logic [23:0] m;
    logic signed [9:0] sh;
    logic [32:0] mag;
    logic [5:0]  rs;
    e = w[30:23];
    m = {1'b0, w[22:0]};
    mag = '0;
    rs = '0;
    if (e == 8'hFF) begin
      if (w[22:0] != '0) return 32'd0;
      mag = 33'h1_0000_0000;
    end else begin
      if (e != 8'd0) m[23] = 1'b1;
      else e = 8'd1;
      sh = $signed({2'b00, e}) - 10'sd119;
      if (sh >= 10'sd8) begin
        mag = 33'h1_0000_0000;
      end else if (sh >= 10'sd0) begin
        mag = {9'b0, m} << sh[2:0];
      end else if (sh > -10'sd32) begin
        rs = 6'(-sh);
        mag = {9'b0, m} >> rs;
      end else begin
        mag = '0;
      end
    end
    if (w[31]) begin
      if (mag >= 33'h0_8000_0000) return 32'h8000_0000;
      return 32'(-mag);
    end
    if (mag > 33'h0_7FFF_FFFF) return 32'h7FFF_FFFF;
    return mag[31:0];
  endfunction

endpackage

// ===== hw/rtl/wsp_div.sv =====
module wsp_div #(
  parameter int CW = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [wsp_pkg::SUM_W-1:0]   dividend,
  input  logic [CW-1:0]               divisor,
  output logic                        busy,
  output logic                        done,
  output logic [31:0]                 quotient
);
  import wsp_pkg::*;

  localparam int NW = $clog2(SUM_W + 1);

  logic [CW-1:0]    rem;
  logic [CW-1:0]    dvs;
  logic [SUM_W-1:0] quo;
  logic [NW-1:0]    cnt;
  logic             neg;
  logic [CW:0]      trial;
  logic             ge;
  logic [SUM_W-1:0] quo_next;

  // one restoring step per cycle
  always_comb begin
    trial    = {rem, quo[SUM_W-1]};
    ge       = trial >= {1'b0, dvs};
    quo_next = {quo[SUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == NW'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // operands and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SUM_W-1];
      quo <= dividend[SUM_W-1] ? -dividend : dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? CW'(trial - {1'b0, dvs}) : trial[CW-1:0];
      quo <= quo_next;
      if (cnt == NW'(SUM_W - 1)) begin
        quotient <= neg ? 32'(-quo_next) : quo_next[31:0];
      end
    end
  end

endmodule

// ===== hw/rtl/wsp_dp.sv =====
module wsp_dp #(
  parameter int MAX_CHANNELS = 8,
  parameter int CW = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  wsp_pkg::cmd_t              cmd,
  input  logic [7:0]                 data_byte,
  output wsp_pkg::status_t           st,
  output logic [wsp_pkg::SUM_W-1:0]  sum_next,
  output logic [CW-1:0]              div_chan,
  output logic [31:0]                rate,
  output logic [15:0]                chans,
  output logic [15:0]                bits,
  output logic                       flt
);
  import wsp_pkg::*;

  logic [31:0] field_count, tag_shift, size_shift, rate_seen, data_left, byte_gather;
  logic [15:0] format_code, channels_seen, bits_seen;
  logic        fmt_found, pad_pending;
  logic [1:0]  guid_match;
  logic [CW-1:0] channel_index;
  logic [SUM_W-1:0] frame_sum;

  // effective values after an optional restart
  logic [31:0] e_count, e_tag, e_size, e_rate, e_left, e_gather;
  logic [15:0] e_fmt, e_chan, e_bits;
  logic        e_found, e_pad;
  logic [1:0]  e_guid;
  logic [CW-1:0] e_idx;
  logic [SUM_W-1:0] e_sum;

  logic [31:0] k1, lane_b, tag_acc, size_acc, gather_acc, keep32;
  logic [15:0] lane16, keep16;
  logic [4:0]  lane_sh;
  logic [1:0]  guid_next;
  logic [3:0]  g;
  logic [7:0]  pe, fe;
  logic        chg, live, chan_done;
  logic [31:0] q31;
  logic [CW:0] idx1;

  assign rate  = rate_seen;
  assign chans = channels_seen;
  assign bits  = bits_seen;
  assign flt   = format_code == FMT_FLOAT;
  assign div_chan = channels_seen[CW-1:0];

  always_comb begin
    e_count  = cmd.restart ? '0 : field_count;
    e_tag    = cmd.restart ? '0 : tag_shift;
    e_size   = cmd.restart ? '0 : size_shift;
    e_rate   = cmd.restart ? '0 : rate_seen;
    e_left   = cmd.restart ? '0 : data_left;
    e_gather = cmd.restart ? '0 : byte_gather;
    e_fmt    = cmd.restart ? '0 : format_code;
    e_chan   = cmd.restart ? '0 : channels_seen;
    e_bits   = cmd.restart ? '0 : bits_seen;
    e_found  = cmd.restart ? 1'b0 : fmt_found;
    e_pad    = cmd.restart ? 1'b0 : pad_pending;
    e_guid   = cmd.restart ? 2'b11 : guid_match;
    e_idx    = cmd.restart ? '0 : channel_index;
    e_sum    = cmd.restart ? '0 : frame_sum;
  end

  // byte placement and accumulators
  always_comb begin
    k1         = e_count + 32'd1;
    lane_sh    = {e_count[1:0], 3'b000};
    lane_b     = {24'b0, data_byte} << lane_sh;
    keep32     = ~(32'hFF << lane_sh);
    lane16     = {8'b0, data_byte} << {e_count[0], 3'b000};
    keep16     = ~(16'hFF << {e_count[0], 3'b000});
    tag_acc    = e_tag | lane_b;
    size_acc   = e_size | lane_b;
    gather_acc = e_gather | lane_b;
  end

  // guid compare
  always_comb begin
    g  = 4'(e_count - 32'd24);
    pe = guid_byte(g, 1'b0);
    fe = guid_byte(g, 1'b1);
    guid_next = e_guid;
    if (cmd.phase == PH_FMT && e_count >= 32'd24 && e_count < 32'd40) begin
      if (data_byte != pe) guid_next[0] = 1'b0;
      if (data_byte != fe) guid_next[1] = 1'b0;
    end
  end

  // sample conversion and frame accumulation
  always_comb begin
    unique case (e_bits)
      16'd8:   q31 = {~gather_acc[7], gather_acc[6:0], 24'b0};
      16'd16:  q31 = {gather_acc[15:0], 16'b0};
      16'd24:  q31 = {gather_acc[23:0], 8'b0};
      default: q31 = gather_acc;
    endcase
    if (e_fmt == FMT_FLOAT) q31 = float_to_q31(gather_acc);
    live      = cmd.phase == PH_DATA && e_left != '0;
    chan_done = k1 >= {19'b0, e_bits[15:3]};
    idx1      = {1'b0, e_idx} + 1'b1;
    sum_next  = e_sum + {{(SUM_W-32){q31[31]}}, q31};
  end

  // status
  always_comb begin
    st.k3          = e_count[1:0] == 2'd3;
    st.tag_riff    = tag_acc == TAG_RIFF;
    st.tag_wave    = tag_acc == TAG_WAVE;
    st.id_fmt      = e_tag == TAG_FMT;
    st.id_data     = e_tag == TAG_DATA;
    st.size_lt16   = size_acc < 32'd16;
    st.size_zero   = size_acc == '0;
    st.size_odd    = size_acc[0];
    st.pad         = e_pad;
    st.count_hit   = k1 == e_size;
    st.fmt_ext     = e_fmt == FMT_EXTENSIBLE;
    st.fmt_plain   = e_fmt == FMT_PCM || e_fmt == FMT_FLOAT;
    st.size_lt40   = e_size < 32'd40;
    st.guid_pcm    = guid_next[0];
    st.guid_flt    = guid_next[1];
    st.fmt_found   = e_found;
    st.bits_zero   = e_bits[15:3] == '0;
    st.chan_zero   = e_chan == '0;
    st.rate_zero   = e_rate == '0;
    st.is_flt      = e_fmt == FMT_FLOAT;
    st.bits32      = e_bits == 16'd32;
    st.bits_pcm_ok = e_bits == 16'd8 || e_bits == 16'd16 || e_bits == 16'd24 ||
                     e_bits == 16'd32;
    st.chan_over   = e_chan > 16'(MAX_CHANNELS);
    st.frame_done  = live && chan_done && {{(16-CW-1){1'b0}}, idx1} >= e_chan;
  end

  assign chg = cmd.next != cmd.phase;

  // register update on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      field_count   <= '0;
      tag_shift     <= '0;
      size_shift    <= '0;
      rate_seen     <= '0;
      data_left     <= '0;
      byte_gather   <= '0;
      format_code   <= '0;
      channels_seen <= '0;
      bits_seen     <= '0;
      fmt_found     <= 1'b0;
      pad_pending   <= 1'b0;
      guid_match    <= 2'b11;
      channel_index <= '0;
      frame_sum     <= '0;
    end else if (cmd.take) begin
      field_count   <= chg ? '0 : k1;
      tag_shift     <= e_tag;
      size_shift    <= e_size;
      rate_seen     <= e_rate;
      data_left     <= e_left;
      byte_gather   <= e_gather;
      format_code   <= e_fmt;
      channels_seen <= e_chan;
      bits_seen     <= e_bits;
      fmt_found     <= e_found;
      pad_pending   <= e_pad;
      guid_match    <= guid_next;
      channel_index <= e_idx;
      frame_sum     <= e_sum;
      unique case (cmd.phase)
        PH_RIFF, PH_WAVE, PH_CHID: begin
          tag_shift <= tag_acc;
        end
        PH_CHSZ: begin
          size_shift <= size_acc;
          if (st.k3) pad_pending <= size_acc[0];
        end
        PH_FMT: begin
          // each byte of the format, channel, rate and bits fields replaces its lane of the field
          if (e_count < 32'd2) begin
            format_code <= (e_fmt & keep32[15:0]) | lane_b[15:0];
          end else if (e_count < 32'd4) begin
            channels_seen <= (e_chan & keep16) | lane16;
          end else if (e_count < 32'd8) begin
            rate_seen <= (e_rate & keep32) | lane_b;
          end else if (e_count == 32'd14 || e_count == 32'd15) begin
            bits_seen <= (e_bits & keep16) | lane16;
          end
          if (cmd.fmt_ok) begin
            fmt_found <= 1'b1;
            if (e_fmt == FMT_EXTENSIBLE) format_code <= guid_next[0] ? FMT_PCM : FMT_FLOAT;
          end
        end
        PH_PAD: begin
          pad_pending <= 1'b0;
        end
        PH_DATA: begin
          if (live) begin
            data_left   <= e_left - 32'd1;
            byte_gather <= gather_acc;
            field_count <= k1;
            if (chan_done) begin
              field_count   <= '0;
              byte_gather   <= '0;
              frame_sum     <= sum_next;
              channel_index <= idx1[CW-1:0];
              if (st.frame_done) begin
                frame_sum     <= '0;
                channel_index <= '0;
              end
            end
          end
        end
        default: begin
        end
      endcase
      // chunk boundaries clear the tag
      if (chg && (cmd.next == PH_WAVE || cmd.next == PH_CHID || cmd.next == PH_PAD)) begin
        tag_shift <= '0;
      end
      if (chg && cmd.next == PH_CHSZ) size_shift <= '0;
      if (chg && cmd.next == PH_FMT) guid_match <= 2'b11;
      if (chg && cmd.next == PH_DATA) begin
        data_left     <= size_acc;
        byte_gather   <= '0;
        channel_index <= '0;
        frame_sum     <= '0;
      end
    end
  end

endmodule

// ===== hw/rtl/wsp_ctrl.sv =====
module wsp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_first,
  input  logic              in_final,
  input  wsp_pkg::status_t  st,
  input  logic              div_busy,
  input  logic              div_done,
  input  logic              out_ready,
  output logic              in_ready,
  output wsp_pkg::cmd_t     cmd,
  output logic              div_start,
  output logic              out_valid,
  output wsp_pkg::kind_t    out_kind,
  output logic [3:0]        out_err
);
  import wsp_pkg::*;

  phase_t phase, ph, nxt;
  logic   take, res, fmt_ok;
  kind_t  res_kind;
  logic [3:0] res_err;

  // input stays closed while the divider runs and while a result waits to be taken
  assign in_ready = !out_valid && !div_busy && !div_done;
  assign take     = in_valid && in_ready;

  // next phase and result for the current byte
  always_comb begin
    ph       = in_first ? PH_RIFF : phase;
    nxt      = ph;
    res      = 1'b0;
    res_kind = KIND_ERROR;
    res_err  = ERR_NOT_RIFF;
    fmt_ok   = 1'b0;
    unique case (ph)
      PH_RIFF: begin
        if (st.k3) begin
          if (!st.tag_riff) begin
            res = 1'b1; res_err = ERR_NOT_RIFF; nxt = PH_DONE;
          end else begin
            nxt = PH_RSIZE;
          end
        end
      end
      PH_RSIZE: begin
        if (st.k3) nxt = PH_WAVE;
      end
      PH_WAVE: begin
        if (st.k3) begin
          if (!st.tag_wave) begin
            res = 1'b1; res_err = ERR_NOT_WAVE; nxt = PH_DONE;
          end else begin
            nxt = PH_CHID;
          end
        end
      end
      PH_CHID: begin
        if (st.k3) nxt = PH_CHSZ;
      end
      PH_CHSZ: begin
        if (st.k3) begin
          if (st.id_fmt) begin
            if (st.size_lt16) begin
              res = 1'b1; res_err = ERR_FMT_SMALL; nxt = PH_DONE;
            end else begin
              nxt = PH_FMT;
            end
          end else if (st.id_data) begin
            res = 1'b1;
            nxt = PH_DONE;
            if (!st.fmt_found) res_err = ERR_MISSING;
            else if (st.bits_zero || st.chan_zero || st.rate_zero) res_err = ERR_LAYOUT;
            else if (st.size_zero || in_final) res_err = ERR_EMPTY;
            else if (st.is_flt && !st.bits32) res_err = ERR_FLOAT_BITS;
            else if (!st.is_flt && !st.bits_pcm_ok) res_err = ERR_UNSUPP;
            else if (st.chan_over) res_err = ERR_UNSUPP;
            else begin
              res_kind = KIND_REPORT;
              res_err  = ERR_NOT_RIFF;
              nxt      = PH_DATA;
            end
          end else if (st.size_zero) begin
            nxt = st.size_odd ? PH_PAD : PH_CHID;
          end else begin
            nxt = PH_SKIP;
          end
        end
      end
      PH_FMT: begin
        if (st.count_hit) begin
          if (st.fmt_ext && st.size_lt40) begin
            res = 1'b1; res_err = ERR_FMT_SMALL; nxt = PH_DONE;
          end else if ((st.fmt_ext && !st.guid_pcm && !st.guid_flt) ||
                       (!st.fmt_ext && !st.fmt_plain)) begin
            res = 1'b1; res_err = ERR_UNSUPP; nxt = PH_DONE;
          end else begin
            fmt_ok = 1'b1;
            nxt    = st.pad ? PH_PAD : PH_CHID;
          end
        end
      end
      PH_SKIP: begin
        if (st.count_hit) nxt = st.pad ? PH_PAD : PH_CHID;
      end
      PH_PAD: begin
        nxt = PH_CHID;
      end
      PH_DATA, PH_DONE: begin
      end
      default: begin
      end
    endcase
    // end of file: an error before the data chunk, and the parse ends in any phase
    if (in_final) begin
      if (!res && nxt != PH_DATA && nxt != PH_DONE) begin
        res      = 1'b1;
        res_kind = KIND_ERROR;
        if (nxt == PH_RIFF) res_err = ERR_NOT_RIFF;
        else if (nxt == PH_WAVE) res_err = ERR_NOT_WAVE;
        else if (nxt == PH_CHID) res_err = ERR_MISSING;
        else res_err = ERR_TRUNCATED;
      end
      nxt = PH_DONE;
    end
  end

  always_comb begin
    cmd.take    = take;
    cmd.restart = in_first;
    cmd.phase   = ph;
    cmd.next    = nxt;
    cmd.fmt_ok  = fmt_ok;
    div_start   = take && st.frame_done;
  end

  // phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_RIFF;
    end else if (take) begin
      phase <= nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_kind  <= KIND_REPORT;
      out_err   <= ERR_NOT_RIFF;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (take && res) begin
        out_valid <= 1'b1;
        out_kind  <= res_kind;
        out_err   <= res_kind == KIND_ERROR ? res_err : ERR_NOT_RIFF;
      end else if (div_done) begin
        out_valid <= 1'b1;
        out_kind  <= KIND_SAMPLE;
        out_err   <= ERR_NOT_RIFF;
      end
    end
  end

endmodule

// ===== hw/rtl/wav_stream_parse_to_mono_unit.sv =====
// RIFF/WAVE parser with mono down-mix. File bytes come in one per request on the
// slave side, one byte per cycle while headers are parsed and channel samples are
// gathered. A byte that yields a format report or an error holds the input until
// that result is taken. The last byte of each frame starts a shared one-bit-per-cycle
// restoring divider (40 steps); the input stalls from that byte until the mono sample
// appears, and it reopens once that sample is taken. tuser on the input restarts the
// parse, tlast ends the file. Output kinds: format report, mono Q1.31 sample, error;
// fields that do not belong to the kind read as zero.
module wav_stream_parse_to_mono_unit #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte
  input  logic         s_axis_tuser,   // first_byte
  input  logic         s_axis_tlast,   // final_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // mono_sample, sample_rate, channel_count, sample_bits, is_float, error_code, zero fill
  output logic [103:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser    // kind
);
  import wsp_pkg::*;

  localparam int CW = $clog2(MAX_CHANNELS + 1);

  cmd_t    cmd;
  status_t st;
  kind_t   kind;
  logic [3:0]       err;
  logic [SUM_W-1:0] sum_next;
  logic [CW-1:0]    div_chan;
  logic [31:0]      rate, q;
  logic [15:0]      chans, bits;
  logic             flt, div_start, div_busy, div_done;
  logic             is_rep, is_smp;

  wsp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_first  (s_axis_tuser),
    .in_final  (s_axis_tlast),
    .st        (st),
    .div_busy  (div_busy),
    .div_done  (div_done),
    .out_ready (m_axis_tready),
    .in_ready  (s_axis_tready),
    .cmd       (cmd),
    .div_start (div_start),
    .out_valid (m_axis_tvalid),
    .out_kind  (kind),
    .out_err   (err)
  );

  wsp_dp #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .CW           (CW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .data_byte (s_axis_tdata),
    .st        (st),
    .sum_next  (sum_next),
    .div_chan  (div_chan),
    .rate      (rate),
    .chans     (chans),
    .bits      (bits),
    .flt       (flt)
  );

  wsp_div #(
    .CW (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_next),
    .divisor  (div_chan),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (q)
  );

  // output packing
  always_comb begin
    is_rep = kind == KIND_REPORT;
    is_smp = kind == KIND_SAMPLE;
    m_axis_tuser = kind;
    m_axis_tdata = {
      3'b000,
      err,
      is_rep & flt,
      is_rep ? bits : 16'd0,
      is_rep ? chans : 16'd0,
      is_rep ? rate : 32'd0,
      is_smp ? q : 32'd0
    };
  end

`include "wav_stream_parse_to_mono_unit_macros.svh"

  `WSP_ASSERT_SAME(a_no_take_while_busy, div_busy, !s_axis_tready, "input open during divide")
  `WSP_ASSERT_SAME(a_done_only_idle, div_done, !m_axis_tvalid, "divider finished over a result")
  `WSP_ASSERT_NEXT(a_one_result, m_axis_tvalid && m_axis_tready, !m_axis_tvalid,
                   "result repeated after request")

endmodule
